// File: sv/tpbt_pkg.sv
`default_nettype none
package tpbt_pkg;

    localparam int DEFAULT_ENTRIES = 256;
    localparam int PTR_W   = 64;
    localparam int ADDR_W  = 48;
    localparam int TAG_W   = PTR_W - ADDR_W;
    localparam int CMD_W   = 2;
    localparam int STS_W   = 3;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESIZE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd3;

    localparam logic [STS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd1;
    localparam logic [STS_W-1:0] STS_NOT_USED = 3'd2;
    localparam logic [STS_W-1:0] STS_BAD_ID   = 3'd3;
    localparam logic [STS_W-1:0] STS_OOB      = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic exec;
        logic link;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic need_link;
    } t_sts;

endpackage
`default_nettype wire

// File: sv/tpbt_req_if.sv
`default_nettype none
interface tpbt_req_if;
    logic                              valid;
    logic                              ready;
    logic [tpbt_pkg::CMD_W-1:0]        cmd;
    logic [tpbt_pkg::PTR_W-1:0]        tagged_ptr;
    logic [tpbt_pkg::ADDR_W-1:0]       new_base;
    logic [tpbt_pkg::ADDR_W-1:0]       obj_length;

    modport source (output valid, cmd, tagged_ptr, new_base, obj_length, input ready);
    modport sink   (input valid, cmd, tagged_ptr, new_base, obj_length, output ready);
endinterface
`default_nettype wire

// File: sv/tpbt_rsp_if.sv
`default_nettype none
interface tpbt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [tpbt_pkg::STS_W-1:0]        status;
    logic [tpbt_pkg::PTR_W-1:0]        out_ptr;
    logic [tpbt_pkg::ADDR_W-1:0]       plain_addr;

    modport source (output valid, status, out_ptr, plain_addr, input ready);
    modport sink   (input valid, status, out_ptr, plain_addr, output ready);
endinterface
`default_nettype wire

// File: sv/tpbt_ram.sv
`default_nettype none
module tpbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/tpbt_ctrl.sv
`default_nettype none
module tpbt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire tpbt_pkg::t_sts i_sts,
    output tpbt_pkg::t_ctl     o_ctl
);
    import tpbt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) n_state = i_sts.need_link ? S_LINK : S_IDLE;
            end
            S_LINK: begin
                n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_ctl.clear_step = 1'b1;
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_ctl.capture = i_req_valid;
            end
            S_EXEC:  o_ctl.exec = i_sts.out_free;
            S_LINK:  o_ctl.link = 1'b1;
            default: o_ctl = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/tpbt_dp.sv
`default_nettype none
module tpbt_dp #(
    parameter int ENTRIES = tpbt_pkg::DEFAULT_ENTRIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tpbt_pkg::t_ctl              i_ctl,
    output tpbt_pkg::t_sts                   o_sts,
    input  wire logic [tpbt_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [tpbt_pkg::PTR_W-1:0]  i_tagged_ptr,
    input  wire logic [tpbt_pkg::ADDR_W-1:0] i_new_base,
    input  wire logic [tpbt_pkg::ADDR_W-1:0] i_obj_length,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [tpbt_pkg::STS_W-1:0]  o_status,
    output logic      [tpbt_pkg::PTR_W-1:0]  o_out_ptr,
    output logic      [tpbt_pkg::ADDR_W-1:0] o_plain_addr
);
    import tpbt_pkg::*;

    localparam int IDW    = $clog2(ENTRIES + 1);  // 1-based id, 0 = none
    localparam int IW     = $clog2(ENTRIES);      // table index
    localparam int META_W = IDW + 1;              // {used, next}
    localparam int BL_W   = 2 * ADDR_W;           // {base, length}
    localparam logic [TAG_W-1:0] TAG_MAX  = TAG_W'(ENTRIES);
    localparam logic [IW-1:0]    IDX_LAST = IW'(ENTRIES - 1);

    // list pointers and sweep counter
    logic [IDW-1:0] r_head, r_tail;
    logic           r_empty;
    logic [IW-1:0]  r_clr;

    // captured transaction
    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_plain, r_nbase, r_nlen;
    logic [IDW-1:0]    r_id;
    logic [IW-1:0]     r_idx, r_link_idx;
    logic              r_id_ok;

    // table memories
    logic              meta_we, bl_we;
    logic [IW-1:0]     meta_waddr, rd_addr;
    logic [META_W-1:0] meta_wdata, meta_rd;
    logic [BL_W-1:0]   bl_rd;

    // input decode
    logic [TAG_W-1:0] in_tag;
    logic [IDW-1:0]   in_id;
    logic             in_id_ok;

    // exec results
    logic              rd_used;
    logic [IDW-1:0]    rd_next;
    logic [ADDR_W-1:0] rd_base, rd_len;
    logic [ADDR_W:0]   hi_bound;
    logic              hit;
    logic [STS_W-1:0]  x_status;
    logic [PTR_W-1:0]  x_ptr;
    logic [ADDR_W-1:0] x_plain;

    assign in_tag   = i_tagged_ptr[PTR_W-1:ADDR_W];
    assign in_id_ok = (in_tag != '0) && (in_tag <= TAG_MAX);
    assign in_id    = (i_cmd == CMD_ALLOC) ? r_head : in_tag[IDW-1:0];
    assign rd_addr  = i_ctl.capture ? IW'(in_id - IDW'(1)) : r_idx;

    assign rd_used = meta_rd[META_W-1];
    assign rd_next = meta_rd[IDW-1:0];
    assign rd_base = bl_rd[BL_W-1:ADDR_W];
    assign rd_len  = bl_rd[ADDR_W-1:0];
    assign hi_bound = {1'b0, rd_base} + {1'b0, rd_len};
    // id is in range and the record is live
    assign hit = r_id_ok && rd_used;

    always_comb begin
        x_status = STS_OK;
        x_ptr    = '0;
        x_plain  = (r_cmd == CMD_RELEASE || r_cmd == CMD_CHECK) ? r_plain : '0;
        case (r_cmd)
            CMD_ALLOC: begin
                if (r_empty) x_status = STS_FULL;
                else         x_ptr    = {TAG_W'(r_id), r_nbase};
            end
            default: begin
                if (!r_id_ok)      x_status = STS_BAD_ID;
                else if (!rd_used) x_status = STS_NOT_USED;
                else if (r_cmd == CMD_RESIZE) begin
                    x_ptr = {TAG_W'(r_id), r_nbase};
                end else if (r_cmd == CMD_CHECK) begin
                    if (r_plain < rd_base || {1'b0, r_plain} > hi_bound) x_status = STS_OOB;
                end
            end
        endcase
    end

    // meta write port: sweep, record update, tail link
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_idx;
        meta_wdata = '0;
        bl_we      = 1'b0;
        if (i_ctl.clear_step) begin
            meta_we    = 1'b1;
            meta_waddr = r_clr;
            meta_wdata = (r_clr == IDX_LAST) ? '0 : {1'b0, IDW'(r_clr) + IDW'(2)};
        end else if (i_ctl.link) begin
            meta_we    = 1'b1;
            meta_waddr = r_link_idx;
            meta_wdata = {1'b0, r_id};
        end else if (i_ctl.exec) begin
            case (r_cmd)
                CMD_ALLOC: begin
                    meta_we    = !r_empty;
                    meta_wdata = {1'b1, IDW'(0)};
                    bl_we      = !r_empty;
                end
                CMD_RELEASE: meta_we = hit;
                CMD_RESIZE:  bl_we   = hit;
                default:     meta_we = 1'b0;
            endcase
        end
    end

    tpbt_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (rd_addr),
        .o_rdata (meta_rd)
    );

    tpbt_ram #(.WIDTH(BL_W), .DEPTH(ENTRIES)) u_bl (
        .i_clk   (i_clk),
        .i_we    (bl_we),
        .i_waddr (r_idx),
        .i_wdata ({r_nbase, r_nlen}),
        .i_raddr (rd_addr),
        .o_rdata (bl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_cmd;
            r_plain <= i_tagged_ptr[ADDR_W-1:0];
            r_nbase <= i_new_base;
            r_nlen  <= i_obj_length;
            r_id    <= in_id;
            r_id_ok <= (i_cmd == CMD_ALLOC) || in_id_ok;
            r_idx   <= IW'(in_id - IDW'(1));
        end
        if (i_ctl.exec) begin
            r_link_idx   <= IW'(r_tail - IDW'(1));
            o_status     <= x_status;
            o_out_ptr    <= x_ptr;
            o_plain_addr <= x_plain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= IDW'(1);
            r_tail      <= IDW'(ENTRIES);
            r_empty     <= 1'b0;
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_ctl.clear_step) r_clr <= r_clr + IW'(1);
            if (i_ctl.exec) begin
                o_out_valid <= 1'b1;
                if (r_cmd == CMD_ALLOC && !r_empty) begin
                    if (r_head == r_tail) begin
                        r_empty <= 1'b1;
                        r_head  <= '0;
                        r_tail  <= '0;
                    end else begin
                        r_head <= rd_next;
                    end
                end else if (r_cmd == CMD_RELEASE && hit) begin
                    if (r_empty) begin
                        r_head  <= r_id;
                        r_empty <= 1'b0;
                    end
                    r_tail <= r_id;
                end
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr == IDX_LAST);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;
    assign o_sts.need_link  = (r_cmd == CMD_RELEASE) && hit && !r_empty;
endmodule
`default_nettype wire

// File: sv/tagged_pointer_bounds_table.sv
// Tagged-pointer bounds table.
// Request channel i_req carries cmd (allocate, release, resize, check), a tagged
// pointer whose bits 63:48 hold a 1-based object id, and base/length for
// allocate and resize. Response channel o_rsp returns status, a tagged
// pointer (allocate/resize) and the untagged address (release/check).
// One transaction per request, in request order.
// Sequence: a request is taken in the idle step, the record is read from
// the table RAM and the result is written to the output register in the
// execute step. A release that appends to a non-empty free list takes an
// extra link step for the write that links the old tail, since the record
// RAM has a single write port.
// Reset: i_req.ready stays low while the record RAM is swept (used flags
// cleared, free list linked 1 -> 2 -> ... -> ENTRIES).
// Stall: the result waits in the output register while o_rsp.ready is low;
// the next request is still taken, but its result is held back (the block
// sits in the execute step) until the output register frees up.
// Base/length of a record that was never written are never used: they
// are reached only through records marked in use.
`default_nettype none
module tagged_pointer_bounds_table #(
    parameter int ENTRIES = tpbt_pkg::DEFAULT_ENTRIES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tpbt_req_if.sink    i_req,
    tpbt_rsp_if.source  o_rsp
);
    import tpbt_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencing: sweep, accept, execute, optional tail link
    tpbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // table RAMs, free list pointers and the output register
    tpbt_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cmd        (i_req.cmd),
        .i_tagged_ptr (i_req.tagged_ptr),
        .i_new_base   (i_req.new_base),
        .i_obj_length (i_req.obj_length),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_out_ptr    (o_rsp.out_ptr),
        .o_plain_addr (o_rsp.plain_addr)
    );
endmodule
`default_nettype wire
